// File: rtl/s2a_pkg.sv
// Shared types, constants and keymap functions for the scan-code decoder.
// No dependencies; imported by s2a_decode and scancode_to_ascii_decoder_top.
package s2a_pkg;

  // Special scan-code values (set 1).
  localparam logic [7:0] PREFIX_BYTE = 8'hE0;
  localparam logic [6:0] KEY_LIMIT   = 7'h3B;
  localparam logic [6:0] MK_CTRL     = 7'h1D;
  localparam logic [6:0] MK_SHIFT_L  = 7'h2A;
  localparam logic [6:0] MK_SHIFT_R  = 7'h36;
  localparam logic [6:0] MK_ALT      = 7'h38;
  localparam logic [6:0] MK_CAPS     = 7'h3A;

  // Modifier and prefix state carried from byte to byte.
  typedef struct packed {
    logic ext_pending;
    logic ctrl_down;
    logic shift_down;
    logic alt_down;
    logic caps_on;
  } mod_state_t;

  // Character part of one decoded result.
  typedef struct packed {
    logic       char_valid;
    logic [6:0] char_code;
    logic       char_dropped;
    logic       unknown_key;
  } char_res_t;

  // Keys whose shifted form ignores caps lock (digits, symbols, controls).
  function automatic logic shift_only_key(input logic [5:0] idx);
    logic r;
    r = (idx < 6'h0E) || (idx == 6'h1A) || (idx == 6'h1B) ||
        ((idx >= 6'h27) && (idx <= 6'h29)) || (idx == 6'h2B) ||
        ((idx >= 6'h33) && (idx <= 6'h35));
    return r;
  endfunction

  // Two-column keymap for make codes 0x00..0x3A; zero means no character.
  function automatic logic [6:0] key_lookup(input logic [5:0] idx, input logic sh);
    logic [6:0] c;
    unique case (idx)
      6'h00: c = 7'h00;
      6'h01: c = 7'h1B;                    // escape
      6'h02: c = sh ? 7'h21 : 7'h31;
      6'h03: c = sh ? 7'h40 : 7'h32;
      6'h04: c = sh ? 7'h23 : 7'h33;
      6'h05: c = sh ? 7'h24 : 7'h34;
      6'h06: c = sh ? 7'h25 : 7'h35;
      6'h07: c = sh ? 7'h5E : 7'h36;
      6'h08: c = sh ? 7'h26 : 7'h37;
      6'h09: c = sh ? 7'h2A : 7'h38;
      6'h0A: c = sh ? 7'h28 : 7'h39;
      6'h0B: c = sh ? 7'h29 : 7'h30;
      6'h0C: c = sh ? 7'h5F : 7'h2D;
      6'h0D: c = sh ? 7'h2B : 7'h3D;
      6'h0E: c = 7'h08;                    // backspace
      6'h0F: c = 7'h09;                    // tab
      6'h10: c = sh ? 7'h51 : 7'h71;
      6'h11: c = sh ? 7'h57 : 7'h77;
      6'h12: c = sh ? 7'h45 : 7'h65;
      6'h13: c = sh ? 7'h52 : 7'h72;
      6'h14: c = sh ? 7'h54 : 7'h74;
      6'h15: c = sh ? 7'h59 : 7'h79;
      6'h16: c = sh ? 7'h55 : 7'h75;
      6'h17: c = sh ? 7'h49 : 7'h69;
      6'h18: c = sh ? 7'h4F : 7'h6F;
      6'h19: c = sh ? 7'h50 : 7'h70;
      6'h1A: c = sh ? 7'h7B : 7'h5B;
      6'h1B: c = sh ? 7'h7D : 7'h5D;
      6'h1C: c = 7'h0D;                    // enter
      6'h1D: c = 7'h00;                    // ctrl
      6'h1E: c = sh ? 7'h41 : 7'h61;
      6'h1F: c = sh ? 7'h53 : 7'h73;
      6'h20: c = sh ? 7'h44 : 7'h64;
      6'h21: c = sh ? 7'h46 : 7'h66;
      6'h22: c = sh ? 7'h47 : 7'h67;
      6'h23: c = sh ? 7'h48 : 7'h68;
      6'h24: c = sh ? 7'h4A : 7'h6A;
      6'h25: c = sh ? 7'h4B : 7'h6B;
      6'h26: c = sh ? 7'h4C : 7'h6C;
      6'h27: c = sh ? 7'h3A : 7'h3B;
      6'h28: c = sh ? 7'h22 : 7'h27;
      6'h29: c = sh ? 7'h7E : 7'h60;
      6'h2A: c = 7'h00;                    // left shift
      6'h2B: c = sh ? 7'h7C : 7'h5C;
      6'h2C: c = sh ? 7'h5A : 7'h7A;
      6'h2D: c = sh ? 7'h58 : 7'h78;
      6'h2E: c = sh ? 7'h43 : 7'h63;
      6'h2F: c = sh ? 7'h56 : 7'h76;
      6'h30: c = sh ? 7'h42 : 7'h62;
      6'h31: c = sh ? 7'h4E : 7'h6E;
      6'h32: c = sh ? 7'h4D : 7'h6D;
      6'h33: c = sh ? 7'h3C : 7'h2C;
      6'h34: c = sh ? 7'h3E : 7'h2E;
      6'h35: c = sh ? 7'h3F : 7'h2F;
      6'h36: c = 7'h00;                    // right shift
      6'h37: c = 7'h2A;                    // keypad star
      6'h38: c = 7'h00;                    // alt
      6'h39: c = 7'h20;                    // space
      6'h3A: c = 7'h00;                    // caps lock
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/s2a_decode.sv
// Single-pass decode of one scan-code byte against the current modifier state.
// Depends on s2a_pkg for the state and result types and the keymap.
module s2a_decode (
  input  logic [7:0]          scan_byte,
  input  logic                sink_full,
  input  s2a_pkg::mod_state_t cur_state,
  output s2a_pkg::mod_state_t nxt_state,
  output s2a_pkg::char_res_t  res
);
  import s2a_pkg::*;

  logic       is_prefix;
  logic       is_break;
  logic [6:0] key;
  logic       ext;
  logic       handled;
  logic [5:0] idx;
  logic       sh;
  logic [6:0] ch;

  // Classify the byte.
  assign is_prefix = (scan_byte == PREFIX_BYTE);
  assign is_break  = scan_byte[7];
  assign key       = scan_byte[6:0];
  assign ext       = cur_state.ext_pending;
  assign handled   = !is_break &&
                     ((!ext && (key != 7'h00) && (key < KEY_LIMIT)) ||
                      (ext && ((key == MK_CTRL) || (key == MK_ALT))));

  // Keymap lookup; letters honor caps lock, the rest use shift only.
  assign idx = scan_byte[5:0];
  assign sh  = (!ext && shift_only_key(idx)) ? cur_state.shift_down :
               (cur_state.shift_down ^ cur_state.caps_on);
  assign ch  = key_lookup(idx, sh);

  // State update and result.
  always_comb begin
    nxt_state = cur_state;
    res       = '0;
    if (is_prefix) begin
      nxt_state.ext_pending = 1'b1;
    end else begin
      nxt_state.ext_pending = 1'b0;
      if (is_break) begin
        if (key == MK_CTRL) begin
          nxt_state.ctrl_down = 1'b0;
        end else if (key == MK_ALT) begin
          nxt_state.alt_down = 1'b0;
        end else if (!ext && ((key == MK_SHIFT_L) || (key == MK_SHIFT_R))) begin
          nxt_state.shift_down = 1'b0;
        end
      end else if (handled) begin
        if (ch != 7'h00) begin
          res.char_code    = ch;
          res.char_dropped = sink_full;
          res.char_valid   = !sink_full;
        end else if (key == MK_CTRL) begin
          nxt_state.ctrl_down = 1'b1;
        end else if ((key == MK_SHIFT_L) || (key == MK_SHIFT_R)) begin
          nxt_state.shift_down = 1'b1;
        end else if (key == MK_ALT) begin
          nxt_state.alt_down = 1'b1;
        end else if (key == MK_CAPS) begin
          nxt_state.caps_on = !cur_state.caps_on;
        end
      end else begin
        res.unknown_key = 1'b1;
      end
    end
  end

endmodule

// File: rtl/scancode_to_ascii_decoder_top.sv
// Top level of the set 1 scan-code to ASCII decoder.
// Depends on s2a_pkg and s2a_decode.
//
// Usage: each request on the in_ channel carries one raw keyboard byte and
// the sink-full flag sampled with it. Each byte yields exactly one result on
// the out_ channel: the decoded character with its valid or dropped flag,
// the unknown-key flag, and the ctrl, shift, alt and caps-lock states after
// that byte. A 0xE0 prefix byte also yields a result, with no character.
// A byte accepted into the input register is decoded combinationally and
// written to the result register once that register is free, which raises
// out_valid; the result is taken when out_valid and out_ready are both high.
// Throughput: one byte per cycle while the receiver does not stall; the
// input and result registers form a two-entry pipeline, and the modifier
// state advances when a byte moves from the input to the result register.
// When the receiver stalls, the result register holds and the input
// register still takes one more byte; in_ready then drops until out_ready.
// Reset (rst_n low, synchronous) empties both registers and clears the
// prefix latch, all modifiers and caps lock.
module scancode_to_ascii_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_scan_byte,
  input  logic       in_sink_full,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_char_valid,
  output logic [6:0] out_char_code,
  output logic       out_char_dropped,
  output logic       out_unknown_key,
  output logic       out_ctrl_held,
  output logic       out_shift_held,
  output logic       out_alt_held,
  output logic       out_caps_on
);
  import s2a_pkg::*;

  logic       in_vld_r;
  logic [7:0] byte_r;
  logic       full_r;
  logic       out_vld_r;
  char_res_t  res_r;
  mod_state_t state_r;
  mod_state_t state_nxt;
  char_res_t  res_nxt;
  logic       advance;

  // Pipeline control: the input register drains into a free result register.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  s2a_decode u_decode (
    .scan_byte (byte_r),
    .sink_full (full_r),
    .cur_state (state_r),
    .nxt_state (state_nxt),
    .res       (res_nxt)
  );

  // Control state: occupancy flags and modifier state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_scan_byte;
      full_r <= in_sink_full;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  // Result port; modifier outputs reflect the state after the shown byte.
  assign out_valid        = out_vld_r;
  assign out_char_valid   = res_r.char_valid;
  assign out_char_code    = res_r.char_code;
  assign out_char_dropped = res_r.char_dropped;
  assign out_unknown_key  = res_r.unknown_key;
  assign out_ctrl_held    = state_r.ctrl_down;
  assign out_shift_held   = state_r.shift_down;
  assign out_alt_held     = state_r.alt_down;
  assign out_caps_on      = state_r.caps_on;

endmodule

// File: rtl/s2a_checker.sv
// Port-level checks for the scan-code decoder, bound to its top level.
// Depends only on the ports of scancode_to_ascii_decoder_top.
module s2a_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_char_valid,
  input logic [6:0] out_char_code,
  input logic       out_char_dropped,
  input logic       out_unknown_key
);

  // The result register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // A character is either delivered or dropped, never both.
  a_valid_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_char_valid && out_char_dropped))
    else $error("character both delivered and dropped");

  // A delivered or dropped character always carries a nonzero code.
  a_code_present: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_char_valid || out_char_dropped)) |-> (out_char_code != 7'h00))
    else $error("character flagged with zero code");

  // An unknown key produces no character at all.
  a_unknown_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_unknown_key) |->
      (!out_char_valid && !out_char_dropped && (out_char_code == 7'h00)))
    else $error("unknown key carries a character");

  // A stalled result holds its character.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_char_code)))
    else $error("stalled result changed");

endmodule

bind scancode_to_ascii_decoder_top s2a_checker u_s2a_checker (.*);

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the set 1 scan-code to ASCII decoder top level.
// Depends on s2a_pkg and scancode_to_ascii_decoder_top; predicts each result
// in a scoreboard class while plain tasks drive directed and random bytes.

import s2a_pkg::*;

// One decoded result as the block presents it on the out_ channel.
typedef struct packed {
  bit       valid;
  bit [6:0] code;
  bit       dropped;
  bit       unknown;
  bit       ctrl;
  bit       shift;
  bit       alt;
  bit       caps;
} key_result_t;

// Keeps its own copy of the prefix and modifier state and the expected results.
class key_scoreboard;
  bit          ext_pending;
  bit          ctrl_down;
  bit          shift_down;
  bit          alt_down;
  bit          caps_on;
  bit [6:0]    plain_map[59];
  bit [6:0]    shift_map[59];
  key_result_t expected_q[$];
  int unsigned mismatches;

  function new();
    // Unshifted column, indexed by make code 0x00..0x3A; zero means no character.
    plain_map = '{7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
                  7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
                  7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00,
                  7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
                  7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
                  7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00};
    // Shifted column, same indexing.
    shift_map = '{7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
                  7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
                  7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00,
                  7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
                  7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
                  7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00};
  endfunction

  // Decodes one accepted request and queues the result it must produce.
  function void note_request(bit [7:0] scan, bit full);
    key_result_t r;
    bit          ext;
    bit [6:0]    key;
    bit          is_letter;
    bit          upper;
    bit [6:0]    ch;
    r = '0;
    if (scan == PREFIX_BYTE) begin
      ext_pending = 1'b1;
    end else begin
      ext = ext_pending;
      ext_pending = 1'b0;
      key = scan[6:0];
      if (scan[7]) begin
        // Only ctrl and alt (either side) and the two plain shifts release.
        if (key == MK_CTRL) begin
          ctrl_down = 1'b0;
        end else if (key == MK_ALT) begin
          alt_down = 1'b0;
        end else if (!ext && (key == MK_SHIFT_L || key == MK_SHIFT_R)) begin
          shift_down = 1'b0;
        end
      end else if ((!ext && key != 7'h00 && key < KEY_LIMIT) ||
                   (ext && (key == MK_CTRL || key == MK_ALT))) begin
        // Caps lock only affects letters; everything else follows shift alone.
        is_letter = plain_map[key] inside {[7'h61:7'h7A]};
        upper = shift_down ^ (caps_on & is_letter);
        ch = upper ? shift_map[key] : plain_map[key];
        if (ch != 7'h00) begin
          r.code = ch;
          r.dropped = full;
          r.valid = !full;
        end else begin
          case (key)
            MK_CTRL:              ctrl_down = 1'b1;
            MK_SHIFT_L, MK_SHIFT_R: shift_down = 1'b1;
            MK_ALT:               alt_down = 1'b1;
            MK_CAPS:              caps_on = !caps_on;
            default: ;
          endcase
        end
      end else begin
        r.unknown = 1'b1;
      end
    end
    r.ctrl = ctrl_down;
    r.shift = shift_down;
    r.alt = alt_down;
    r.caps = caps_on;
    expected_q.push_back(r);
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compares one accepted result against the oldest expectation.
  function void check_result(key_result_t got);
    key_result_t want;
    if (expected_q.size() == 0) begin
      $error("result arrived with no expectation pending");
      mismatches++;
      return;
    end
    want = expected_q.pop_front();
    compare_field("char_valid", want.valid, got.valid);
    compare_field("char_code", want.code, got.code);
    compare_field("char_dropped", want.dropped, got.dropped);
    compare_field("unknown_key", want.unknown, got.unknown);
    compare_field("ctrl_held", want.ctrl, got.ctrl);
    compare_field("shift_held", want.shift, got.shift);
    compare_field("alt_held", want.alt, got.alt);
    compare_field("caps_on", want.caps, got.caps);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned ITEMS_PER_PHASE = 317;
  localparam int unsigned SETTLE_CYCLES = 10;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_scan_byte;
  logic       in_sink_full;
  logic       out_valid;
  logic       out_ready;
  logic       out_char_valid;
  logic [6:0] out_char_code;
  logic       out_char_dropped;
  logic       out_unknown_key;
  logic       out_ctrl_held;
  logic       out_shift_held;
  logic       out_alt_held;
  logic       out_caps_on;

  key_scoreboard sb = new();
  int unsigned   tx_idle_pct;
  int unsigned   rx_idle_pct;
  int unsigned   sent_count;
  int unsigned   cycle_count;

  scancode_to_ascii_decoder_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_scan_byte     (in_scan_byte),
    .in_sink_full     (in_sink_full),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char_valid   (out_char_valid),
    .out_char_code    (out_char_code),
    .out_char_dropped (out_char_dropped),
    .out_unknown_key  (out_unknown_key),
    .out_ctrl_held    (out_ctrl_held),
    .out_shift_held   (out_shift_held),
    .out_alt_held     (out_alt_held),
    .out_caps_on      (out_caps_on)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // The receiver stalls at random; out_ready changes on the falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Results are taken on the rising edge where valid and ready are both high.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(key_result_t'({out_char_valid, out_char_code, out_char_dropped,
                                     out_unknown_key, out_ctrl_held, out_shift_held,
                                     out_alt_held, out_caps_on}));
    end
  end

  // Presents one request after a random gap and waits until it is taken.
  task automatic send_byte(input bit [7:0] scan, input bit full);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_scan_byte <= scan;
    in_sink_full <= full;
    do @(posedge clk); while (!in_ready);
    sb.note_request(scan, full);
    sent_count++;
  endtask

  // Mostly well-formed typing: key makes and breaks, modifiers, prefixed
  // right ctrl and alt, plus some raw noise bytes.
  task automatic send_random_keystroke();
    bit [6:0] mods[5];
    int       pick;
    bit       full;
    bit       brk;
    mods = '{MK_CTRL, MK_SHIFT_L, MK_SHIFT_R, MK_ALT, MK_CAPS};
    pick = $urandom_range(99);
    full = ($urandom_range(3) == 0);
    brk = 1'($urandom_range(1));
    if (pick < 45) begin
      send_byte({1'b0, 7'($urandom_range(1, 7'h3A))}, full);
    end else if (pick < 58) begin
      send_byte({1'b1, 7'($urandom_range(1, 7'h3A))}, full);
    end else if (pick < 72) begin
      send_byte({brk, mods[$urandom_range(4)]}, full);
    end else if (pick < 84) begin
      send_byte(PREFIX_BYTE, full);
      if ($urandom_range(3) == 0) begin
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        send_byte({brk, ($urandom_range(1) ? MK_CTRL : MK_ALT)}, full);
      end
    end else begin
      send_byte(8'($urandom_range(255)), full);
    end
  endtask

  task automatic run_random_phase(input int unsigned tx_pct, input int unsigned rx_pct);
    int unsigned stop_at;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at = sent_count + ITEMS_PER_PHASE;
    while (sent_count < stop_at) send_random_keystroke();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_scan_byte = 8'h00;
    in_sink_full = 1'b0;
    out_ready = 1'b0;
    tx_idle_pct = 10;
    rx_idle_pct = 77;
    sent_count = 0;
    cycle_count = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: keymap ends, shift versus caps lock, full sink, modifier
    // makes and breaks, repeated prefix, ignored breaks, unknown keys.
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte({1'b0, MK_SHIFT_L}, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte({1'b0, MK_CAPS}, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h0C, 1'b0);
    send_byte({1'b1, MK_SHIFT_L}, 1'b0);
    send_byte(8'h1E, 1'b1);
    send_byte({1'b0, MK_CAPS}, 1'b0);
    send_byte({1'b0, MK_CTRL}, 1'b0);
    send_byte({1'b1, MK_CTRL}, 1'b0);
    send_byte(PREFIX_BYTE, 1'b0);
    send_byte(PREFIX_BYTE, 1'b0);
    send_byte({1'b0, MK_CTRL}, 1'b0);
    send_byte(PREFIX_BYTE, 1'b0);
    send_byte({1'b1, MK_CTRL}, 1'b0);
    send_byte({1'b0, MK_ALT}, 1'b0);
    send_byte(PREFIX_BYTE, 1'b0);
    send_byte({1'b1, MK_ALT}, 1'b0);
    send_byte(PREFIX_BYTE, 1'b0);
    send_byte({1'b0, MK_SHIFT_R}, 1'b0);
    send_byte({1'b0, MK_SHIFT_R}, 1'b0);
    send_byte(PREFIX_BYTE, 1'b0);
    send_byte({1'b1, MK_SHIFT_R}, 1'b0);
    send_byte({1'b0, KEY_LIMIT}, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h39, 1'b1);

    run_random_phase(10, 77);
    run_random_phase(77, 10);
    run_random_phase(0, 0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
